### rtl/core/chip8_instruction_core_assert.svh
// Assertion macros used by the checker of the instruction core.
`ifndef CHIP8_INSTRUCTION_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C8_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/core/c8core_pkg.sv
// ----------------------------------------------------------------------------
// c8core_pkg
// Types, opcode constants, font table and helpers of the instruction core.
// ----------------------------------------------------------------------------
package c8core_pkg;

	localparam logic [1:0] KIND_EXEC = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_LOAD = 2'd2;

	localparam logic [11:0] PC_RESET = 12'h200;
	localparam logic [4:0]  NO_KEY   = 5'd16;
	localparam logic [3:0]  FLAG_REG = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [3:0] NIB_SYS  = 4'h0;
	localparam logic [3:0] NIB_JP   = 4'h1;
	localparam logic [3:0] NIB_CALL = 4'h2;
	localparam logic [3:0] NIB_SE   = 4'h3;
	localparam logic [3:0] NIB_SNE  = 4'h4;
	localparam logic [3:0] NIB_SER  = 4'h5;
	localparam logic [3:0] NIB_LD   = 4'h6;
	localparam logic [3:0] NIB_ADD  = 4'h7;
	localparam logic [3:0] NIB_ALU  = 4'h8;
	localparam logic [3:0] NIB_SNER = 4'h9;
	localparam logic [3:0] NIB_LDI  = 4'hA;
	localparam logic [3:0] NIB_JPV  = 4'hB;
	localparam logic [3:0] NIB_RND  = 4'hC;
	localparam logic [3:0] NIB_DRW  = 4'hD;
	localparam logic [3:0] NIB_KEY  = 4'hE;
	localparam logic [3:0] NIB_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [7:0] FN_GETDT = 8'h07;
	localparam logic [7:0] FN_WAITK = 8'h0A;
	localparam logic [7:0] FN_SETDT = 8'h15;
	localparam logic [7:0] FN_SETST = 8'h18;
	localparam logic [7:0] FN_ADDI  = 8'h1E;
	localparam logic [7:0] FN_FONT  = 8'h29;
	localparam logic [7:0] FN_BCD   = 8'h33;
	localparam logic [7:0] FN_STORE = 8'h55;
	localparam logic [7:0] FN_LOAD  = 8'h65;
	localparam logic [7:0] FN_SKP   = 8'h9E;
	localparam logic [7:0] FN_SKNP  = 8'hA1;

	localparam int IN_W       = 48;
	localparam int OUT_W      = 64;
	localparam int FONT_BYTES = 80;

	localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_CLEAR,
		CMD_TICK,
		CMD_LOAD,
		CMD_RD_HI,
		CMD_RD_LO,
		CMD_DECODE,
		CMD_OPND,
		CMD_EXEC,
		CMD_FLAG,
		CMD_ST_RD,
		CMD_ST_WR,
		CMD_LD_RD,
		CMD_LD_WR,
		CMD_BCD0,
		CMD_BCD1,
		CMD_BCD2,
		CMD_RESULT
	} cmd_t;

	typedef enum logic [2:0] {
		CLS_SIMPLE,
		CLS_FLAG,
		CLS_STORE,
		CLS_LOAD,
		CLS_BCD
	} op_class_t;

	typedef struct packed {
		logic [1:0] kind;
		op_class_t  op_class;
		logic       clr_last;
		logic       blk_last;
		logic       out_free;
	} status_t;

	function automatic logic [7:0] font_byte(input logic [6:0] idx);
		return FONT_ROM[idx];
	endfunction

	function automatic logic key_pressed(input logic [15:0] keys, input logic [7:0] k);
		return (k[7:4] == 4'd0) ? keys[k[3:0]] : 1'b0;
	endfunction

	function automatic logic [4:0] lowest_key(input logic [15:0] keys);
		logic [4:0] r;
		r = NO_KEY;
		for (int i = 15; i >= 0; i--) begin
			if (keys[i]) r = 5'(i);
		end
		return r;
	endfunction

endpackage

### rtl/core/c8core_dp.sv
// ----------------------------------------------------------------------------
// c8core_dp
// Datapath: memory, register file, PC, I, stack, timers and result register.
// ----------------------------------------------------------------------------
module c8core_dp
	import c8core_pkg::*;
#(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output status_t          st,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam int MA_W = $clog2(MEM_BYTES);
	localparam int SI_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam logic [14:0] M1 = 15'(MEM_BYTES);
	localparam logic [14:0] M2 = 15'(2 * MEM_BYTES);
	localparam logic [14:0] M4 = 15'(4 * MEM_BYTES);

	function automatic logic [MA_W-1:0] map_addr(input logic [11:0] a);
		logic [14:0] v;
		v = {3'b0, a};
		if (v >= M4) v = v - M4;
		if (v >= M2) v = v - M2;
		if (v >= M1) v = v - M1;
		return v[MA_W-1:0];
	endfunction

	// item latches
	logic [1:0]  kind_q;
	logic [11:0] ld_addr_q;
	logic [7:0]  ld_data_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;

	logic [15:0] op_q;
	logic [11:0] pc_q;
	logic [11:0] idx_q;
	logic [SP_W-1:0] sp_q;
	logic [11:0] stack_q [STACK_DEPTH];
	logic [7:0]  dt_q;
	logic [7:0]  st_q;
	logic [4:0]  latch_q;
	logic        wait_q;
	logic        flag_q;
	logic [3:0]  cnt_q;
	logic [MA_W-1:0] clr_q;

	logic [7:0]  mem [MEM_BYTES];
	logic [7:0]  mem_rd_q;
	logic [7:0]  regs [16];
	logic [15:0] rvalid_q;
	logic [7:0]  va_q;
	logic [7:0]  vb_q;

	logic            m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [3:0]  nib;
	logic [3:0]  x;
	logic [3:0]  y;
	logic [3:0]  n;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [11:0] pc_inc;
	logic [11:0] pc_skip;
	logic [11:0] pc_next;

	always_comb begin
		nib     = op_q[15:12];
		x       = op_q[11:8];
		y       = op_q[7:4];
		n       = op_q[3:0];
		nn      = op_q[7:0];
		nnn     = op_q[11:0];
		pc_inc  = pc_q + 12'd2;
		pc_skip = pc_q + 12'd4;
	end

	// ALU
	logic [8:0] sum9;
	logic [7:0] alu_val;
	logic       alu_flag;
	logic       alu_we;

	always_comb begin
		sum9     = {1'b0, va_q} + {1'b0, vb_q};
		alu_val  = va_q;
		alu_flag = 1'b0;
		alu_we   = 1'b1;
		case (n)
			ALU_MOV: alu_val = vb_q;
			ALU_OR:  alu_val = va_q | vb_q;
			ALU_AND: alu_val = va_q & vb_q;
			ALU_XOR: alu_val = va_q ^ vb_q;
			ALU_ADD: begin
				alu_val  = sum9[7:0];
				alu_flag = sum9[8];
			end
			ALU_SUB: begin
				alu_val  = va_q - vb_q;
				alu_flag = va_q >= vb_q;
			end
			ALU_SHR: begin
				alu_val  = {1'b0, vb_q[7:1]};
				alu_flag = vb_q[0];
			end
			ALU_RSB: begin
				alu_val  = vb_q - va_q;
				alu_flag = vb_q >= va_q;
			end
			ALU_SHL: begin
				alu_val  = {vb_q[6:0], 1'b0};
				alu_flag = vb_q[7];
			end
			default: alu_we = 1'b0;
		endcase
	end

	// key wait
	logic [4:0] lk_cand;
	logic       key_wait;

	always_comb begin
		lk_cand  = (latch_q >= NO_KEY) ? lowest_key(keys_q) : latch_q;
		key_wait = (lk_cand >= NO_KEY) || key_pressed(keys_q, {3'b0, lk_cand});
	end

	// decimal digits of V[x]
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_r;
	logic [14:0] bcd_p;
	logic [3:0]  bcd_t;
	logic [7:0]  bcd_o;

	always_comb begin
		if (va_q >= 8'd200)      bcd_h = 2'd2;
		else if (va_q >= 8'd100) bcd_h = 2'd1;
		else                     bcd_h = 2'd0;
		bcd_r = va_q - {6'b0, bcd_h} * 8'd100;
		bcd_p = 15'(bcd_r) * 15'd205;
		bcd_t = bcd_p[14:11];
		bcd_o = bcd_r - {4'b0, bcd_t} * 8'd10;
	end

	// stack pointer moves
	logic [SP_W-1:0] sp_call;
	logic [SP_W-1:0] sp_ret;

	always_comb begin
		sp_call = (sp_q >= SP_W'(STACK_DEPTH)) ? '0 : sp_q;
		if (sp_q == '0)                        sp_ret = '0;
		else if (sp_q > SP_W'(STACK_DEPTH))    sp_ret = SP_W'(STACK_DEPTH - 1);
		else                                   sp_ret = sp_q - 1'b1;
	end

	// next PC on execute
	always_comb begin
		pc_next = pc_inc;
		unique case (nib)
			NIB_SYS:  if (op_q == OP_RET) pc_next = stack_q[sp_ret[SI_W-1:0]];
			NIB_JP:   pc_next = nnn;
			NIB_CALL: pc_next = nnn;
			NIB_SE:   if (va_q == nn) pc_next = pc_skip;
			NIB_SNE:  if (va_q != nn) pc_next = pc_skip;
			NIB_SER:  if (va_q == vb_q) pc_next = pc_skip;
			NIB_SNER: if (va_q != vb_q) pc_next = pc_skip;
			NIB_JPV:  pc_next = nnn + {4'b0, va_q};
			NIB_KEY: begin
				if (nn == FN_SKP && key_pressed(keys_q, va_q)) pc_next = pc_skip;
				else if (nn == FN_SKNP && !key_pressed(keys_q, va_q)) pc_next = pc_skip;
			end
			NIB_MISC: if (nn == FN_WAITK && key_wait) pc_next = pc_q;
			default:  pc_next = pc_inc;
		endcase
	end

	// register file write port
	logic       rf_we;
	logic [3:0] rf_wa;
	logic [7:0] rf_wd;
	logic [3:0] rf_ra;

	always_comb begin
		rf_we = 1'b0;
		rf_wa = x;
		rf_wd = alu_val;
		case (cmd)
			CMD_EXEC: begin
				unique case (nib)
					NIB_LD: begin
						rf_we = 1'b1;
						rf_wd = nn;
					end
					NIB_ADD: begin
						rf_we = 1'b1;
						rf_wd = va_q + nn;
					end
					NIB_ALU: rf_we = alu_we;
					NIB_RND: begin
						rf_we = 1'b1;
						rf_wd = rnd_q & nn;
					end
					NIB_MISC: begin
						if (nn == FN_GETDT) begin
							rf_we = 1'b1;
							rf_wd = dt_q;
						end else if (nn == FN_WAITK && !key_wait) begin
							rf_we = 1'b1;
							rf_wd = {3'b0, lk_cand};
						end
					end
					default: rf_we = 1'b0;
				endcase
			end
			CMD_FLAG: begin
				rf_we = 1'b1;
				rf_wa = FLAG_REG;
				rf_wd = {7'b0, flag_q};
			end
			CMD_LD_WR: begin
				rf_we = 1'b1;
				rf_wa = cnt_q;
				rf_wd = mem_rd_q;
			end
			default: rf_we = 1'b0;
		endcase
		if (cmd == CMD_ST_RD)   rf_ra = cnt_q;
		else if (nib == NIB_JPV) rf_ra = 4'd0;
		else                     rf_ra = x;
	end

	always_ff @(posedge clk) begin
		if (rf_we) regs[rf_wa] <= rf_wd;
		if (cmd == CMD_OPND || cmd == CMD_ST_RD) begin
			va_q <= rvalid_q[rf_ra] ? regs[rf_ra] : 8'd0;
			vb_q <= rvalid_q[y] ? regs[y] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
		end else if (rf_we) begin
			rvalid_q[rf_wa] <= 1'b1;
		end
	end

	// memory port
	logic [11:0]     ma_raw;
	logic [MA_W-1:0] ma;
	logic            mem_we;
	logic [7:0]      mem_wd;

	always_comb begin
		ma_raw = idx_q;
		mem_we = 1'b0;
		mem_wd = va_q;
		case (cmd)
			CMD_LOAD: begin
				ma_raw = ld_addr_q;
				mem_we = 1'b1;
				mem_wd = ld_data_q;
			end
			CMD_RD_HI: ma_raw = pc_q;
			CMD_RD_LO: ma_raw = pc_q + 12'd1;
			CMD_ST_WR: mem_we = 1'b1;
			CMD_BCD0: begin
				mem_we = 1'b1;
				mem_wd = {6'b0, bcd_h};
			end
			CMD_BCD1: begin
				ma_raw = idx_q + 12'd1;
				mem_we = 1'b1;
				mem_wd = {4'b0, bcd_t};
			end
			CMD_BCD2: begin
				ma_raw = idx_q + 12'd2;
				mem_we = 1'b1;
				mem_wd = bcd_o;
			end
			CMD_CLEAR: begin
				mem_we = 1'b1;
				mem_wd = (clr_q < MA_W'(FONT_BYTES)) ? font_byte(clr_q[6:0]) : 8'd0;
			end
			default: mem_we = 1'b0;
		endcase
		ma = (cmd == CMD_CLEAR) ? clr_q : map_addr(ma_raw);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[ma] <= mem_wd;
		mem_rd_q <= mem[ma];
	end

	// item latch, opcode and flag
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				kind_q    <= s_tuser;
				ld_addr_q <= s_tdata[11:0];
				ld_data_q <= s_tdata[19:12];
				keys_q    <= s_tdata[35:20];
				rnd_q     <= s_tdata[43:36];
				op_q      <= '0;
			end
			CMD_RD_LO:  op_q[15:8] <= mem_rd_q;
			CMD_DECODE: op_q[7:0]  <= mem_rd_q;
			CMD_EXEC:   flag_q     <= alu_flag;
			default: ;
		endcase
		if (cmd == CMD_EXEC && nib == NIB_CALL) stack_q[sp_call[SI_W-1:0]] <= pc_inc;
	end

	// architectural control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= PC_RESET;
			idx_q   <= '0;
			sp_q    <= '0;
			dt_q    <= '0;
			st_q    <= '0;
			latch_q <= NO_KEY;
			wait_q  <= 1'b0;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			case (cmd)
				CMD_CLEAR:  clr_q <= clr_q + 1'b1;
				CMD_ACCEPT: wait_q <= 1'b0;
				CMD_TICK: begin
					if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
					if (st_q != 8'd0) st_q <= st_q - 8'd1;
				end
				CMD_DECODE: cnt_q <= '0;
				CMD_EXEC: begin
					pc_q <= pc_next;
					if (nib == NIB_CALL) sp_q <= sp_call + 1'b1;
					if (op_q == OP_RET) sp_q <= sp_ret;
					if (nib == NIB_LDI) idx_q <= nnn;
					if (nib == NIB_MISC) begin
						case (nn)
							FN_WAITK: begin
								wait_q  <= key_wait;
								latch_q <= key_wait ? lk_cand : NO_KEY;
							end
							FN_SETDT: dt_q  <= va_q;
							FN_SETST: st_q  <= va_q;
							FN_ADDI:  idx_q <= idx_q + {4'b0, va_q};
							FN_FONT:  idx_q <= {8'b0, va_q[3:0]} * 12'd5;
							default: ;
						endcase
					end
				end
				CMD_ST_WR, CMD_LD_WR: begin
					idx_q <= idx_q + 12'd1;
					cnt_q <= cnt_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// result register
	logic        is_draw;
	logic [OUT_W-1:0] res;

	always_comb begin
		is_draw = (nib == NIB_DRW);
		res = {wait_q, (st_q != 8'd0),
			is_draw ? idx_q : 12'd0,
			is_draw ? n : 4'd0,
			is_draw ? vb_q : 8'd0,
			is_draw ? va_q : 8'd0,
			(op_q == OP_CLS), is_draw, op_q, pc_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd == CMD_RESULT) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_RESULT) m_tdata_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// status to the controller
	op_class_t cls;

	always_comb begin
		cls = CLS_SIMPLE;
		if (nib == NIB_MISC && nn == FN_STORE)     cls = CLS_STORE;
		else if (nib == NIB_MISC && nn == FN_LOAD) cls = CLS_LOAD;
		else if (nib == NIB_MISC && nn == FN_BCD)  cls = CLS_BCD;
		else if (nib == NIB_ALU && alu_we && n != ALU_MOV) cls = CLS_FLAG;
		st.kind     = kind_q;
		st.op_class = cls;
		st.clr_last = (clr_q == MA_W'(MEM_BYTES - 1));
		st.blk_last = (cnt_q == x);
		st.out_free = !m_tvalid_q || m_tready;
	end

endmodule

### rtl/core/c8core_ctrl.sv
// ----------------------------------------------------------------------------
// c8core_ctrl
// Sequencer: steps the datapath through clear, tick or load, fetch, execute and result.
// ----------------------------------------------------------------------------
module c8core_ctrl
	import c8core_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_FETCH_HI,
		S_FETCH_LO,
		S_DECODE,
		S_OPND,
		S_EXEC,
		S_FLAG,
		S_ST_RD,
		S_ST_WR,
		S_LD_RD,
		S_LD_WR,
		S_BCD0,
		S_BCD1,
		S_BCD2_RESULT
	} state_t;

	// one extra state to wait for the result slot
	typedef enum logic {
		R_WORK,
		R_RESULT
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	always_comb begin
		cmd = CMD_NONE;
		if (phase_q == R_RESULT) begin
			cmd = st.out_free ? CMD_RESULT : CMD_NONE;
		end else begin
			unique case (state_q)
				S_CLEAR:    cmd = CMD_CLEAR;
				S_IDLE:     cmd = s_tvalid ? CMD_ACCEPT : CMD_NONE;
				S_DISPATCH: begin
					unique case (st.kind)
						KIND_TICK: cmd = CMD_TICK;
						KIND_LOAD: cmd = CMD_LOAD;
						default:   cmd = CMD_NONE;
					endcase
				end
				S_FETCH_HI:    cmd = CMD_RD_HI;
				S_FETCH_LO:    cmd = CMD_RD_LO;
				S_DECODE:      cmd = CMD_DECODE;
				S_OPND:        cmd = CMD_OPND;
				S_EXEC:        cmd = CMD_EXEC;
				S_FLAG:        cmd = CMD_FLAG;
				S_ST_RD:       cmd = CMD_ST_RD;
				S_ST_WR:       cmd = CMD_ST_WR;
				S_LD_RD:       cmd = CMD_LD_RD;
				S_LD_WR:       cmd = CMD_LD_WR;
				S_BCD0:        cmd = CMD_BCD0;
				S_BCD1:        cmd = CMD_BCD1;
				S_BCD2_RESULT: cmd = CMD_BCD2;
				default:       cmd = CMD_NONE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE) && (phase_q == R_WORK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			phase_q <= R_WORK;
		end else if (phase_q == R_RESULT) begin
			if (st.out_free) begin
				phase_q <= R_WORK;
				state_q <= S_IDLE;
			end
		end else begin
			unique case (state_q)
				S_CLEAR: if (st.clr_last) state_q <= S_IDLE;
				S_IDLE:  if (s_tvalid) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					if (st.kind == KIND_EXEC) state_q <= S_FETCH_HI;
					else phase_q <= R_RESULT;
				end
				S_FETCH_HI: state_q <= S_FETCH_LO;
				S_FETCH_LO: state_q <= S_DECODE;
				S_DECODE:   state_q <= S_OPND;
				S_OPND:     state_q <= S_EXEC;
				S_EXEC: begin
					unique case (st.op_class)
						CLS_FLAG:  state_q <= S_FLAG;
						CLS_STORE: state_q <= S_ST_RD;
						CLS_LOAD:  state_q <= S_LD_RD;
						CLS_BCD:   state_q <= S_BCD0;
						default:   phase_q <= R_RESULT;
					endcase
				end
				S_FLAG:  phase_q <= R_RESULT;
				S_ST_RD: state_q <= S_ST_WR;
				S_ST_WR: begin
					if (st.blk_last) phase_q <= R_RESULT;
					else state_q <= S_ST_RD;
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: begin
					if (st.blk_last) phase_q <= R_RESULT;
					else state_q <= S_LD_RD;
				end
				S_BCD0:        state_q <= S_BCD1;
				S_BCD1:        state_q <= S_BCD2_RESULT;
				S_BCD2_RESULT: phase_q <= R_RESULT;
				default:       state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 instruction core: execute, timer tick and memory load transactions.
// ----------------------------------------------------------------------------
// One transaction at a time, through a single-port byte memory. A timer tick,
// a load or an unknown kind is dispatched and then gives its result; an
// instruction is fetched as two bytes, decoded, reads its operands, executes,
// adds a flag write for 8xyN, three digit writes for Fx33, and a read and a
// write per byte for Fx55 and Fx65, whose bytes move one at a time over the
// memory port, and then gives its result. The next transaction is taken once
// the result is loaded in the output register. After reset a clearing pass writes
// the font and zeros to all MEM_BYTES addresses before the first transaction.
module chip8_instruction_core
	import c8core_pkg::*;
#(
	parameter int MEM_BYTES   = 4096,
	parameter int STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// load_addr[11:0], load_data[19:12], keys[35:20], random_byte[43:36]
	input  logic [IN_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// pc_now[11:0], opcode_seen[27:12], draw_request[28], clear_request[29],
	// draw_x[37:30], draw_y[45:38], draw_rows[49:46], draw_addr[61:50],
	// sound_on[62], waiting_for_key[63]
	output logic [OUT_W-1:0] m_tdata
);

	cmd_t    cmd;
	status_t st;

	c8core_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	c8core_dp #(
		.MEM_BYTES   (MEM_BYTES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### rtl/core/c8core_checker.sv
// ----------------------------------------------------------------------------
// c8core_checker
// Port-level checks of the instruction core, bound to the top level.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_assert.svh"

module c8core_checker
	import c8core_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic [1:0]       s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	`C8_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`C8_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while busy")
	`C8_ASSERT_NOW(a_req_excl, m_tvalid, !(m_tdata[28] && m_tdata[29]), "draw and clear together")
	`C8_ASSERT_NOW(a_draw_zero, m_tvalid && !m_tdata[28], m_tdata[61:30] == '0, "draw fields without draw")
	`C8_ASSERT_NOW(a_no_op_flags, m_tvalid && m_tdata[27:12] == '0, !m_tdata[28] && !m_tdata[29] && !m_tdata[63], "flags without opcode")

endmodule

bind chip8_instruction_core c8core_checker u_c8core_checker (.*);
